// ===== rtl/tsi_pkg.sv =====
// ----------------------------------------------------------------------------
// Track selection and isolation package
// Shared types, constants and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package tsi_pkg;

  localparam logic [1:0] CFG_PT_MIN  = 2'd0;
  localparam logic [1:0] CFG_DZ_MAX  = 2'd1;
  localparam logic [1:0] CFG_CONE_SQ = 2'd2;

  localparam logic [15:0] PT_MIN_RST  = 16'd80;
  localparam logic [14:0] DZ_MAX_RST  = 15'd102;
  localparam logic [23:0] CONE_SQ_RST = 24'd94372;

  localparam logic signed [13:0] PHI_HALF = 14'sd3217;
  localparam logic signed [13:0] PHI_TURN = 14'sd6434;
  localparam logic [21:0] ISO_MAX = 22'h3FFFFF;
  localparam logic [6:0]  RES_MAX = 7'd64;

  localparam logic signed [15:0] PDG_E  = 16'sd11;
  localparam logic signed [15:0] PDG_MU = 16'sd13;

  typedef struct packed {
    logic [15:0]        pt;
    logic signed [12:0] eta;
    logic signed [12:0] phi;
    logic signed [15:0] dz;
    logic signed [2:0]  charge;
    logic signed [15:0] pdg;
  } track_t;

  typedef struct packed {
    logic [15:0] pt_min;
    logic [14:0] dz_max;
    logic [23:0] cone_sq;
  } cfg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RDO,
    B_LAT,
    B_INNER,
    B_DRAIN,
    B_TAKE,
    B_FINAL
  } back_state_t;

  function automatic logic dz_ok(input logic signed [15:0] dz, input logic [14:0] lim);
    logic [16:0] mag;
    mag = dz[15] ? 17'(-{dz[15], dz}) : {1'b0, dz};
    return mag < {2'b00, lim};
  endfunction

  function automatic logic is_lepton(input logic signed [15:0] pdg);
    return (pdg == PDG_E) || (pdg == -PDG_E) || (pdg == PDG_MU) || (pdg == -PDG_MU);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/track_select_isolation.sv =====
// ----------------------------------------------------------------------------
// Track selection with cone isolation
// Loads one event's tracks, then emits selected tracks with isolation sums.
// ----------------------------------------------------------------------------
// Loading takes one track per cycle while busy is low; busy rises after the last track.
// Each selected track is scanned against all N stored tracks of its event
// (one store read per track in the inner loop); a rejected one is not scanned.
// Results are strobed for one cycle each; an event yields at least one.
// Synchronous reset clears counters and state and restores register defaults.
`default_nettype none

module track_select_isolation #(
  parameter int MAX_TRACKS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [15:0]        pt,
  input  wire logic signed [12:0] eta,
  input  wire logic signed [12:0] phi,
  input  wire logic signed [15:0] dz,
  input  wire logic signed [2:0]  charge,
  input  wire logic signed [15:0] pdg_id,
  input  wire logic               last,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_data,
  output logic                    res_strobe,
  output logic                    valid_res,
  output logic [5:0]              track_index,
  output logic [15:0]             pt_out,
  output logic signed [2:0]       charge_out,
  output logic signed [15:0]      pdg_out,
  output logic signed [15:0]      dz_out,
  output logic [21:0]             isolation,
  output logic                    overflow,
  output logic                    end_of_event
);

  import tsi_pkg::*;

  localparam int AW = $clog2(MAX_TRACKS);
  localparam int CW = $clog2(MAX_TRACKS + 1);

  cfg_t          cfg;
  logic          accept;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  track_t        wdata;
  track_t        rdata;
  logic          push;
  logic [CW:0]   push_data;
  logic          pop;
  logic          q_valid;
  logic [CW:0]   q_data;
  logic          active;

  assign accept = start && !busy;
  assign busy   = q_valid || active;
  assign wdata  = '{pt: pt, eta: eta, phi: phi, dz: dz, charge: charge, pdg: pdg_id};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pt_min  <= PT_MIN_RST;
      cfg.dz_max  <= DZ_MAX_RST;
      cfg.cone_sq <= CONE_SQ_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PT_MIN:  cfg.pt_min  <= cfg_data[15:0];
        CFG_DZ_MAX:  cfg.dz_max  <= cfg_data[14:0];
        CFG_CONE_SQ: cfg.cone_sq <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tsi_front #(.MAX_TRACKS(MAX_TRACKS), .AW(AW), .CW(CW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .last      (last),
    .we        (we),
    .waddr     (waddr),
    .push      (push),
    .push_data (push_data)
  );

  tsi_ram #(.WIDTH($bits(track_t)), .DEPTH(MAX_TRACKS)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  tsi_queue #(.WIDTH(CW + 1), .DEPTH(2)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (q_data)
  );

  tsi_back #(.AW(AW), .CW(CW)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (pop),
    .raddr        (raddr),
    .rdata        (rdata),
    .active       (active),
    .res_strobe   (res_strobe),
    .valid_res    (valid_res),
    .track_index  (track_index),
    .pt_out       (pt_out),
    .charge_out   (charge_out),
    .pdg_out      (pdg_out),
    .dz_out       (dz_out),
    .isolation    (isolation),
    .overflow     (overflow),
    .end_of_event (end_of_event)
  );

endmodule

`default_nettype wire

// ===== rtl/tsi_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/tsi_queue.sv =====
// ----------------------------------------------------------------------------
// Event queue
// Short FIFO of closed-event descriptors between the loader and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module tsi_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      head
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [PW:0]      fill;
  logic             do_pop;

  assign not_empty = fill != '0;
  assign head      = slots[rp];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      fill <= fill + (push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tsi_front.sv =====
// ----------------------------------------------------------------------------
// Track loader
// Writes each accepted track into the store until it is full and closes the event on last.
// ----------------------------------------------------------------------------
`default_nettype none

module tsi_front #(
  parameter int MAX_TRACKS = 64,
  parameter int AW = 6,
  parameter int CW = 7
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic            last,
  output logic                 we,
  output logic [AW-1:0]        waddr,
  output logic                 push,
  output logic [CW:0]          push_data
);

  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic          ovf;
  logic          ovf_next;
  logic          full;

  assign full      = cnt == CW'(MAX_TRACKS);
  assign we        = accept && !full;
  assign waddr     = cnt[AW-1:0];
  assign cnt_next  = full ? cnt : cnt + 1'b1;
  assign ovf_next  = ovf || full;
  assign push      = accept && last;
  assign push_data = {ovf_next, cnt_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ovf <= 1'b0;
    end else if (accept) begin
      cnt <= last ? '0 : cnt_next;
      ovf <= last ? 1'b0 : ovf_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tsi_back.sv =====
// ----------------------------------------------------------------------------
// Isolation engine
// Scans a closed event, sums cone isolation per selected track and emits.
// ----------------------------------------------------------------------------
`default_nettype none

module tsi_back #(
  parameter int AW = 6,
  parameter int CW = 7
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tsi_pkg::cfg_t      cfg,
  input  wire logic               q_valid,
  input  wire logic [CW:0]        q_data,
  output logic                    q_pop,
  output logic [AW-1:0]           raddr,
  input  wire tsi_pkg::track_t    rdata,
  output logic                    active,
  output logic                    res_strobe,
  output logic                    valid_res,
  output logic [5:0]              track_index,
  output logic [15:0]             pt_out,
  output logic signed [2:0]       charge_out,
  output logic signed [15:0]      pdg_out,
  output logic signed [15:0]      dz_out,
  output logic [21:0]             isolation,
  output logic                    overflow,
  output logic                    end_of_event
);

  import tsi_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [AW-1:0] i;
  logic [AW-1:0] j;
  logic [CW-1:0] cnt;
  logic          ovf;
  logic [6:0]    nsel;
  track_t        cur;
  logic          cur_lep;
  logic [21:0]   acc;

  logic          held_v;
  logic [5:0]    held_idx;
  logic [15:0]   held_pt;
  logic [2:0]    held_charge;
  logic [15:0]   held_pdg;
  logic [15:0]   held_dz;
  logic [21:0]   held_iso;

  logic          v1, v2, v3, v4;
  logic [AW-1:0] r1_j;
  logic          s2_skip;
  logic signed [13:0] s2_de;
  logic signed [12:0] s2_dp;
  logic [15:0]   s2_pt;
  logic          s3_skip;
  logic [26:0]   s3_se;
  logic [23:0]   s3_sp;
  logic [15:0]   s3_pt;
  logic          s4_hit;
  logic [15:0]   s4_pt;

  logic          sel;
  logic          i_last;
  logic          j_last;
  logic [AW+5:0] i_wide;
  logic          c1_skip;
  logic signed [13:0] c1_de;
  logic signed [13:0] c1_dp;
  logic signed [13:0] c1_dpw;
  logic signed [27:0] c2_se;
  logic signed [25:0] c2_sp;
  logic [27:0]   c3_d2;
  logic [22:0]   c4_sum;

  assign sel    = (rdata.pt > cfg.pt_min) && dz_ok(rdata.dz, cfg.dz_max) && (rdata.charge != '0);
  assign i_last = (CW'(i) + CW'(1)) == cnt;
  assign j_last = (CW'(j) + CW'(1)) == cnt;
  assign i_wide = {6'd0, i};

  assign c1_skip = (r1_j == i) || !dz_ok(rdata.dz, cfg.dz_max) ||
                   (cur_lep && is_lepton(rdata.pdg));
  assign c1_de   = 14'(cur.eta) - 14'(rdata.eta);
  assign c1_dp   = 14'(cur.phi) - 14'(rdata.phi);
  always_comb begin
    if (c1_dp > PHI_HALF) begin
      c1_dpw = c1_dp - PHI_TURN;
    end else if (c1_dp < -PHI_HALF) begin
      c1_dpw = c1_dp + PHI_TURN;
    end else begin
      c1_dpw = c1_dp;
    end
  end
  assign c2_se  = s2_de * s2_de;
  assign c2_sp  = s2_dp * s2_dp;
  assign c3_d2  = {1'b0, s3_se} + {4'd0, s3_sp};
  assign c4_sum = {1'b0, acc} + {7'd0, s4_pt};

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          state_next = B_RDO;
        end
      end
      B_RDO: state_next = B_LAT;
      B_LAT: begin
        if (sel) begin
          state_next = B_INNER;
        end else if (i_last) begin
          state_next = B_FINAL;
        end else begin
          state_next = B_RDO;
        end
      end
      B_INNER: begin
        if (j_last) begin
          state_next = B_DRAIN;
        end
      end
      B_DRAIN: begin
        if (!v1 && !v2 && !v3 && !v4) begin
          state_next = B_TAKE;
        end
      end
      B_TAKE: begin
        if (i_last || (7'(nsel + 1'b1) == RES_MAX)) begin
          state_next = B_FINAL;
        end else begin
          state_next = B_RDO;
        end
      end
      B_FINAL: state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = state == B_IDLE;
    active       = state != B_IDLE;
    raddr        = (state == B_INNER) ? j : i;
    res_strobe   = ((state == B_TAKE) && held_v) || (state == B_FINAL);
    end_of_event = state == B_FINAL;
    overflow     = ovf;
    valid_res    = held_v;
    track_index  = held_v ? held_idx : '0;
    pt_out       = held_v ? held_pt : '0;
    charge_out   = held_v ? held_charge : '0;
    pdg_out      = held_v ? held_pdg : '0;
    dz_out       = held_v ? held_dz : '0;
    isolation    = held_v ? held_iso : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      held_v <= 1'b0;
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      v4     <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= state == B_INNER;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      if (state == B_IDLE) begin
        held_v <= 1'b0;
      end else if (state == B_TAKE) begin
        held_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    r1_j    <= j;
    s2_skip <= c1_skip;
    s2_de   <= c1_de;
    s2_dp   <= c1_dpw[12:0];
    s2_pt   <= rdata.pt;
    s3_skip <= s2_skip;
    s3_se   <= c2_se[26:0];
    s3_sp   <= c2_sp[23:0];
    s3_pt   <= s2_pt;
    s4_hit  <= !s3_skip && (c3_d2 < {4'd0, cfg.cone_sq});
    s4_pt   <= s3_pt;
    case (state)
      B_IDLE: begin
        i    <= '0;
        nsel <= '0;
        cnt  <= q_data[CW-1:0];
        ovf  <= q_data[CW];
      end
      B_LAT: begin
        cur     <= rdata;
        cur_lep <= is_lepton(rdata.pdg);
        j       <= '0;
        acc     <= '0;
        if (!sel) begin
          i <= i + 1'b1;
        end
      end
      B_INNER: begin
        j <= j + 1'b1;
      end
      B_TAKE: begin
        held_idx    <= i_wide[5:0];
        held_pt     <= cur.pt;
        held_charge <= cur.charge;
        held_pdg    <= cur.pdg;
        held_dz     <= cur.dz;
        held_iso    <= acc;
        nsel        <= nsel + 1'b1;
        i           <= i + 1'b1;
      end
      default: begin
      end
    endcase
    if (v4 && s4_hit) begin
      acc <= c4_sum[22] ? ISO_MAX : c4_sum[21:0];
    end
  end

endmodule

`default_nettype wire
